// File: sv/bbc_pkg.sv
`timescale 1ns / 1ps

package bbc_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 64;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Command queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    // Bracket kinds as kept on the stack. KIND_ANY marks a character that
    // closes any kind.
    localparam logic [1:0] KIND_ROUND  = 2'd0;
    localparam logic [1:0] KIND_CURLY  = 2'd1;
    localparam logic [1:0] KIND_SQUARE = 2'd2;
    localparam logic [1:0] KIND_ANY    = 2'd3;

    // Failure codes reported in fail_reason.
    localparam logic [2:0] FAIL_NONE     = 3'd0;
    localparam logic [2:0] FAIL_MISMATCH = 3'd1;
    localparam logic [2:0] FAIL_EMPTY    = 3'd2;
    localparam logic [2:0] FAIL_OVERFLOW = 3'd3;
    localparam logic [2:0] FAIL_UNCLOSED = 3'd4;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic       is_balanced;
        logic [2:0] fail_reason;
    } t_out_item;

    // Classified character as it travels from the front to the back.
    typedef struct packed {
        logic       is_open;
        logic [1:0] kind;
        logic       last;
    } t_cmd;

endpackage

// File: sv/bbc_ram.sv
`timescale 1ns / 1ps

module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/bbc_front.sv
`timescale 1ns / 1ps

module bbc_front
    import bbc_pkg::*;
(
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    output logic     o_in_ready,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_ready
);

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;

    // Every character that is not an opener behaves as a closer; those that
    // are not closing brackets accept any kind.
    always_comb begin
        o_cmd.last    = i_in_item.last_char;
        o_cmd.is_open = 1'b0;
        o_cmd.kind    = KIND_ANY;
        unique case (i_in_item.char_code)
            CH_LPAREN: begin
                o_cmd.is_open = 1'b1;
                o_cmd.kind    = KIND_ROUND;
            end
            CH_LCURLY: begin
                o_cmd.is_open = 1'b1;
                o_cmd.kind    = KIND_CURLY;
            end
            CH_LSQUARE: begin
                o_cmd.is_open = 1'b1;
                o_cmd.kind    = KIND_SQUARE;
            end
            CH_RPAREN:  o_cmd.kind = KIND_ROUND;
            CH_RCURLY:  o_cmd.kind = KIND_CURLY;
            CH_RSQUARE: o_cmd.kind = KIND_SQUARE;
            default:    o_cmd.kind = KIND_ANY;
        endcase
    end

    assign o_cmd_valid = i_in_valid;
    assign o_in_ready  = i_cmd_ready;

endmodule

// File: sv/bbc_cmd_fifo.sv
`timescale 1ns / 1ps

module bbc_cmd_fifo
    import bbc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_cmd i_push_cmd,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_pop_cmd,
    input  logic i_pop_ready
);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [QP_W-1:0]  r_wptr, n_wptr;
    logic [QP_W-1:0]  r_rptr, n_rptr;
    logic [QC_W-1:0]  r_count, n_count;
    logic             push_en, pop_en;

    assign o_push_ready = (r_count != QC_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_slot[r_rptr];

    assign push_en = i_push_valid && o_push_ready;
    assign pop_en  = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wptr  = push_en ? QP_W'(r_wptr + 1'b1) : r_wptr;
        n_rptr  = pop_en ? QP_W'(r_rptr + 1'b1) : r_rptr;
        n_count = r_count;
        if (push_en && !pop_en) begin
            n_count = QC_W'(r_count + 1'b1);
        end else if (pop_en && !push_en) begin
            n_count = QC_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_slot[r_wptr] <= i_push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QC_W'(QUEUE_DEPTH))
        else $error("command queue count out of range");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QC_W'(QUEUE_DEPTH)) |-> (r_wptr == r_rptr))
        else $error("command queue pointers disagree with count");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_en && !pop_en) |=> (r_count == QC_W'($past(r_count) + 1'b1)))
        else $error("command queue count missed a write");

endmodule

// File: sv/bbc_back.sv
`timescale 1ns / 1ps

module bbc_back
    import bbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_ready,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_ready
);

    logic [CNT_W-1:0] r_depth, n_depth;
    logic [2:0]       r_fail, n_fail;
    logic [1:0]       r_top, n_top;
    logic             r_top_in_ram, n_top_in_ram;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic             take;
    logic             push_en, pop_en;
    logic [1:0]       eff_top, ram_rdata;
    logic [2:0]       end_code;
    logic [CNT_W-1:0] below_top;

    // Characters that make no result never wait on the output register.
    assign o_cmd_ready = !i_cmd.last || !r_out_valid || i_out_ready;
    assign take        = i_cmd_valid && o_cmd_ready;

    // Right after a pop the new top comes out of the RAM read port.
    assign eff_top   = r_top_in_ram ? ram_rdata : r_top;
    assign below_top = CNT_W'(r_depth - 2'd2);

    always_comb begin
        n_depth      = r_depth;
        n_fail       = r_fail;
        n_top        = eff_top;
        n_top_in_ram = 1'b0;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        push_en      = 1'b0;
        pop_en       = 1'b0;
        end_code     = FAIL_NONE;

        if (take && r_fail == FAIL_NONE) begin
            if (i_cmd.is_open) begin
                if (r_depth == CNT_W'(STACK_DEPTH)) begin
                    n_fail = FAIL_OVERFLOW;
                end else begin
                    push_en = 1'b1;
                end
            end else if (r_depth == '0) begin
                n_fail = FAIL_EMPTY;
            end else if (i_cmd.kind != KIND_ANY && i_cmd.kind != eff_top) begin
                n_fail = FAIL_MISMATCH;
            end else begin
                pop_en = 1'b1;
            end
        end

        if (push_en) begin
            n_depth = CNT_W'(r_depth + 1'b1);
            n_top   = i_cmd.kind;
        end else if (pop_en) begin
            n_depth      = CNT_W'(r_depth - 1'b1);
            n_top_in_ram = 1'b1;
        end

        if (take && i_cmd.last) begin
            end_code = n_fail;
            if (end_code == FAIL_NONE && n_depth != '0) begin
                end_code = FAIL_UNCLOSED;
            end
            n_out_valid       = 1'b1;
            n_out.is_balanced = (end_code == FAIL_NONE);
            n_out.fail_reason = end_code;
            n_depth           = '0;
            n_fail            = FAIL_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth      <= '0;
            r_fail       <= FAIL_NONE;
            r_top_in_ram <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_depth      <= n_depth;
            r_fail       <= n_fail;
            r_top_in_ram <= n_top_in_ram;
            r_out_valid  <= n_out_valid;
        end
        r_top <= n_top;
        r_out <= n_out;
    end

    bbc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (push_en),
        .i_waddr (r_depth[SP_W-1:0]),
        .i_wdata (i_cmd.kind),
        .i_raddr (below_top[SP_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CNT_W'(STACK_DEPTH))
        else $error("bracket stack depth beyond capacity");

    a_clear_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cmd.last) |=> (r_depth == '0 && r_fail == FAIL_NONE && o_out_valid))
        else $error("string end did not clear state or raise a result");

    a_result_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.is_balanced == (o_out_item.fail_reason == FAIL_NONE)))
        else $error("balanced flag disagrees with failure code");

    a_no_push_after_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fail != FAIL_NONE) |-> (!push_en && !pop_en))
        else $error("stack moved after a failure");

endmodule

// File: sv/bracket_balance_checker_unit.sv
`timescale 1ns / 1ps

// Bracket balance checker. The block takes one character of a string per
// item, with last_char set on the string's final character, and gives exactly
// one result item per string: is_balanced, and fail_reason holding the first
// failure (1 kind mismatch, 2 closer on an empty stack, 3 push onto a full
// stack, 4 brackets left open). Opening round, curly and square brackets are
// pushed onto a 64-entry stack; any other character pops the top entry and,
// if it is a closing bracket, must match its kind. Characters after the first
// failure are ignored until the string ends, and the state is cleared for the
// next string. The block takes one item every clock cycle while the command
// queue has room: the top of the stack lives in a register, and after a pop
// the new top is taken straight from the registered read port of the stack
// RAM, which reads the entry below the top every cycle. A result's valid is
// registered: the last character passes through the four-entry command
// queue, and the back turns it into the result as it leaves the queue's head,
// straight into the output register. Non-final characters keep flowing while
// a result waits at the output; only a final character waits for the output
// register.
module bracket_balance_checker_unit
    import bbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_ready
);

    logic front_valid, front_ready;
    t_cmd front_cmd;
    logic back_valid, back_ready;
    t_cmd back_cmd;

    // The front classifies each character into a push or pop command.
    bbc_front u_front (
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_ready  (o_in_ready),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (front_ready)
    );

    // The queue lets the front keep accepting items while the back waits.
    bbc_cmd_fifo u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_cmd   (front_cmd),
        .o_push_ready (front_ready),
        .o_pop_valid  (back_valid),
        .o_pop_cmd    (back_cmd),
        .i_pop_ready  (back_ready)
    );

    // The back runs the stack and produces the per-string result.
    bbc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (back_valid),
        .i_cmd       (back_cmd),
        .o_cmd_ready (back_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_ready (i_out_ready)
    );

endmodule

// File: tb/sv/tb_bracket_balance_checker_unit.sv
`timescale 1ns / 1ps

import bbc_pkg::*;

// Tracks the bracket stack of the string in flight and holds the results that
// the block still owes, oldest first.
class bracket_scoreboard;
    logic [1:0]  open_kinds[STACK_DEPTH];
    int unsigned open_count;
    logic [2:0]  first_fail;
    t_out_item   verdict_q[$];
    int unsigned errors;

    function new();
        open_count = 0;
        first_fail = FAIL_NONE;
        errors     = 0;
    endfunction

    // Advances the expected stack by one accepted character and queues the
    // verdict when the character ends its string.
    function void note_char(t_in_item it);
        logic [1:0] open_k;
        logic [1:0] close_k;
        logic [2:0] code;
        t_out_item  verdict;
        open_k  = KIND_ANY;
        close_k = KIND_ANY;
        case (it.char_code)
            "(": open_k = KIND_ROUND;
            "{": open_k = KIND_CURLY;
            "[": open_k = KIND_SQUARE;
            ")": close_k = KIND_ROUND;
            "}": close_k = KIND_CURLY;
            "]": close_k = KIND_SQUARE;
            default: ;
        endcase
        if (first_fail == FAIL_NONE) begin
            if (open_k != KIND_ANY) begin
                if (open_count >= STACK_DEPTH) begin
                    first_fail = FAIL_OVERFLOW;
                end else begin
                    open_kinds[open_count] = open_k;
                    open_count++;
                end
            end else if (open_count == 0) begin
                first_fail = FAIL_EMPTY;
            end else if (close_k != KIND_ANY && close_k != open_kinds[open_count - 1]) begin
                first_fail = FAIL_MISMATCH;
            end else begin
                open_count--;
            end
        end
        if (it.last_char) begin
            code = first_fail;
            if (code == FAIL_NONE && open_count != 0) begin
                code = FAIL_UNCLOSED;
            end
            verdict.is_balanced = (code == FAIL_NONE);
            verdict.fail_reason = code;
            verdict_q.insert(verdict_q.size(), verdict);
            open_count = 0;
            first_fail = FAIL_NONE;
        end
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        if (verdict_q.size() == 0) begin
            $error("unexpected result item: is_balanced %0d fail_reason %0d",
                   got.is_balanced, got.fail_reason);
            errors++;
        end else begin
            want = verdict_q.pop_front();
            if (got.is_balanced !== want.is_balanced) begin
                $error("is_balanced: expected %0d, actual %0d",
                       want.is_balanced, got.is_balanced);
                errors++;
            end
            if (got.fail_reason !== want.fail_reason) begin
                $error("fail_reason: expected %0d, actual %0d",
                       want.fail_reason, got.fail_reason);
                errors++;
            end
        end
    endfunction
endclass

module tb_bracket_balance_checker_unit;

    localparam int CLK_HALF     = 2;
    localparam int RANDOM_CHARS = 1150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;
    logic      out_ready = 1'b0;

    int unsigned cycles     = 0;
    int unsigned burst_left = 0;
    int unsigned chars_sent = 0;

    bracket_scoreboard sb = new();

    bracket_balance_checker_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_ready (out_ready)
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
    end

    // Receiver: the stall style changes in turn, from always ready
    // through coin flips to long stalls.
    always @(posedge clk) begin
        int unsigned style;
        style = (cycles / 150) % 4;
        if (rst_n && out_valid && out_ready) begin
            sb.check_result(out_item);
        end
        case (style)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ((cycles % 23) > 15);
        endcase
    end

    // Presents one character and holds it until taken. Between bursts the
    // valid line drops.
    task automatic send_char(input logic [7:0] code, input logic is_last);
        t_in_item it;
        it.char_code = code;
        it.last_char = is_last;
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_char(it);
        chars_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
        end
    endtask

    task automatic send_literal(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    task automatic send_text(input logic [7:0] text[$]);
        for (int i = 0; i < text.size(); i++) begin
            send_char(text[i], i == text.size() - 1);
        end
    endtask

    function automatic logic [7:0] opener_char(input int unsigned k);
        case (k)
            0: return "(";
            1: return "{";
            default: return "[";
        endcase
    endfunction

    function automatic logic [7:0] closer_char(input int unsigned k);
        case (k)
            0: return ")";
            1: return "}";
            default: return "]";
        endcase
    endfunction

    function automatic logic [7:0] any_bracket();
        int unsigned k;
        k = $urandom_range(0, 5);
        return (k < 3) ? opener_char(k) : closer_char(k - 3);
    endfunction

    // A byte that is neither an opener nor a closer.
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == "(" || c == "{" || c == "[" || c == ")" || c == "}" || c == "]");
        return c;
    endfunction

    // Builds one random string: mostly properly nested text, sometimes
    // spoiled in one spot, sometimes deep or overflowing, sometimes noise.
    task automatic build_string(output logic [7:0] text[$]);
        int unsigned pick;
        int unsigned cap;
        int unsigned target;
        int unsigned kinds[$];
        int unsigned pos;
        text = {};
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            // Fill the stack, then keep pushing.
            repeat (STACK_DEPTH + $urandom_range(1, 3)) begin
                text.insert(text.size(), opener_char($urandom_range(0, 2)));
            end
            repeat ($urandom_range(0, 3)) begin
                text.insert(text.size(), 8'($urandom_range(0, 255)));
            end
        end else if (pick < 75) begin
            cap    = (pick < 6) ? STACK_DEPTH : $urandom_range(1, 8);
            target = (pick < 6) ? 2 * STACK_DEPTH : $urandom_range(2, 14);
            while (text.size() < target || kinds.size() != 0) begin
                if (kinds.size() == 0 ||
                    (kinds.size() < cap && text.size() < target && $urandom_range(0, 1))) begin
                    kinds.insert(kinds.size(), $urandom_range(0, 2));
                    text.insert(text.size(), opener_char(kinds[kinds.size() - 1]));
                end else if ($urandom_range(0, 6) == 0) begin
                    kinds.delete(kinds.size() - 1);
                    text.insert(text.size(), plain_char());
                end else begin
                    text.insert(text.size(), closer_char(kinds[kinds.size() - 1]));
                    kinds.delete(kinds.size() - 1);
                end
            end
            if ($urandom_range(0, 9) < 3) begin
                pos = $urandom_range(0, text.size() - 1);
                case ($urandom_range(0, 3))
                    0: text[pos] = any_bracket();
                    1: if (text.size() > 1) text.delete(text.size() - 1);
                    2: text.push_front(closer_char($urandom_range(0, 2)));
                    default: text.insert(text.size(), opener_char($urandom_range(0, 2)));
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 12)) begin
                text.insert(text.size(),
                            $urandom_range(0, 1) ? any_bracket() : 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        logic [7:0] text[$];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings: each kind balanced, nesting, a kind mismatch,
        // closers on an empty stack, a plain byte closing a bracket, brackets
        // left open, and characters ignored after the first failure.
        send_literal("()");
        send_literal("{}");
        send_literal("[]");
        send_literal("([{}])");
        send_literal("(]");
        send_literal(")");
        send_char(8'h00, 1'b1);
        send_char("{", 1'b0);
        send_char(8'hFF, 1'b1);
        send_literal("((");
        send_literal("])(");
        // Push past a full stack, then a closer that must be ignored.
        text = {};
        repeat (STACK_DEPTH + 1) begin
            text.insert(text.size(), opener_char($urandom_range(0, 2)));
        end
        text.insert(text.size(), ")");
        send_text(text);

        chars_sent = 0;
        while (chars_sent < RANDOM_CHARS) begin
            build_string(text);
            send_text(text);
        end
        in_valid <= 1'b0;

        while (sb.verdict_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.verdict_q.size() == 0) begin
            $display("bracket_balance_checker_unit test passed");
        end else begin
            $display("bracket_balance_checker_unit test failed");
        end
        $finish;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) @(posedge clk);
        $display("bracket_balance_checker_unit test failed");
        $finish;
    end

endmodule

// File: bracket_balance_checker_unit.f
sv/bbc_pkg.sv
sv/bbc_ram.sv
sv/bbc_front.sv
sv/bbc_cmd_fifo.sv
sv/bbc_back.sv
sv/bracket_balance_checker_unit.sv
tb/sv/tb_bracket_balance_checker_unit.sv
